// ===== rtl/cosg_pkg.sv =====
// Shared types, constants and square root step function for the circle outline span generator.
package cosg_pkg;

  localparam int ROW_W       = 11;
  localparam int COL_W       = 12;
  localparam int RADIUS_W    = 10;
  localparam int THICK_W     = 5;
  localparam int CFG_W       = 10;
  localparam int MAX_RADIUS  = 1023;
  localparam int MR_W        = 12;
  localparam int THICK_MAX   = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int ODD_W       = RADIUS_W + 1;
  localparam int RT_W        = RADIUS_W;
  localparam int SQ_W        = 2 * RT_W;
  localparam int REM_W       = RT_W + 3;
  localparam int STEPS_PER_STAGE = 2;
  localparam int N_STAGES    = RT_W / STEPS_PER_STAGE;

  // One row as it travels from the front to the back.
  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic [THICK_W-1:0]      t;
    logic [SQ_W-1:0]         n1;
    logic [SQ_W-1:0]         n2;
  } cosg_job_t;

  // Side info carried alongside each root through the root pipeline.
  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic [THICK_W-1:0]      t;
    logic                    second;
  } cosg_tag_t;

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [SQ_W-1:0]  rest;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
  } root_st_t;

  // One result bit: bring down two radicand bits and try (4*root + 1).
  function automatic root_st_t root_step(root_st_t s);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    root_st_t         o;
    cur    = {s.rem[REM_W-3:0], s.rest[SQ_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    o.rest = {s.rest[SQ_W-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = cur - trial;
      o.root = {s.root[RT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {s.root[RT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic root_st_t root_stage(root_st_t s);
    root_st_t o;
    o = s;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      o = root_step(o);
    end
    return o;
  endfunction

endpackage

// ===== rtl/circle_outline_span_generator_top.sv =====
// Top level of the thick circle outline span generator: configuration and block wiring.
// A row passes the front stages, the queue, the root pipeline and its output register;
//   the right span is shown first, the left span once the right span is taken.
// The shared root pipeline takes one radicand per cycle unless the output stalls it,
//   and each row needs two radicands (outer and inner edge).
// Rows outside the circle are dropped at the front and give no transfer.
// Reset (rst_ni low, asynchronous) empties all stages and loads radius 330, thickness 5.
module circle_outline_span_generator_top #(
  parameter int QUEUE_DEPTH = cosg_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_addr_i,
  input  logic [cosg_pkg::CFG_W-1:0]         cfg_wdata_i,
  // row input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cosg_pkg::ROW_W-1:0]  row_offset_i,
  // span output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cosg_pkg::ROW_W-1:0]  span_row_o,
  output logic signed [cosg_pkg::COL_W-1:0]  x_from_o,
  output logic signed [cosg_pkg::COL_W-1:0]  x_to_o,
  output logic                               is_left_o,
  output logic                               last_o
);
  import cosg_pkg::*;

  typedef enum logic [0:0] {
    REG_RADIUS    = 1'b0,
    REG_THICKNESS = 1'b1
  } cfg_reg_e;

  logic [RADIUS_W-1:0] radius_q;
  logic [THICK_W-1:0]  thickness_q;

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  cosg_job_t job_in;
  cosg_job_t job_out;

  // Configuration registers: user writes only while no row is in flight; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RADIUS_W'(330);
      thickness_q <= THICK_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_RADIUS:    radius_q    <= cfg_wdata_i[RADIUS_W-1:0];
        REG_THICKNESS: thickness_q <= cfg_wdata_i[THICK_W-1:0];
        default:       radius_q    <= radius_q;
      endcase
    end
  end

  // Front: clamp the registers, reject rows with |j| > r, square and form
  // the radicands r^2-(|j|-1)^2 and r^2-|j|^2 over two stages.
  cosg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .row_offset_i (row_offset_i),
    .radius_i     (radius_q),
    .thickness_i  (thickness_q),
    .push_o       (push),
    .job_o        (job_in),
    .full_i       (full)
  );

  // Decouple the front from the back so each side stalls on its own.
  cosg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // Back: two roots per row through one pipeline, then the right span and
  // the left span from the output register.
  cosg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .span_row_o  (span_row_o),
    .x_from_o    (x_from_o),
    .x_to_o      (x_to_o),
    .is_left_o   (is_left_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/cosg_front.sv =====
// Front end: accepts rows, drops rows outside the circle, forms the two radicands.
module cosg_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cosg_pkg::ROW_W-1:0]   row_offset_i,
  input  logic [cosg_pkg::RADIUS_W-1:0]       radius_i,
  input  logic [cosg_pkg::THICK_W-1:0]        thickness_i,
  output logic                                push_o,
  output cosg_pkg::cosg_job_t                 job_o,
  input  logic                                full_i
);
  import cosg_pkg::*;

  logic [ROW_W-1:0]    abs_j;
  logic [RADIUS_W-1:0] r_sat;
  logic [THICK_W-1:0]  t_sat;
  logic                in_circle;
  logic [ODD_W-1:0]    odd_d;
  logic                s1_go;
  logic                s2_free;
  logic [SQ_W-1:0]     n2;

  logic                    s1_valid_q;
  logic signed [ROW_W-1:0] s1_row_q;
  logic [RADIUS_W-1:0]     s1_aj_q;
  logic [RADIUS_W-1:0]     s1_r_q;
  logic [THICK_W-1:0]      s1_t_q;
  logic [ODD_W-1:0]        s1_odd_q;

  logic                    s2_valid_q;
  logic signed [ROW_W-1:0] s2_row_q;
  logic [THICK_W-1:0]      s2_t_q;
  logic [ODD_W-1:0]        s2_odd_q;
  logic [SQ_W-1:0]         s2_rr_q;
  logic [SQ_W-1:0]         s2_aa_q;

  always_comb begin
    abs_j = row_offset_i[ROW_W-1] ? ROW_W'(-row_offset_i) : row_offset_i;
    r_sat = (MR_W'(radius_i) > MR_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_i;
    if (thickness_i == '0) begin
      t_sat = THICK_W'(1);
    end else if (thickness_i > THICK_W'(THICK_MAX)) begin
      t_sat = THICK_W'(THICK_MAX);
    end else begin
      t_sat = thickness_i;
    end
    in_circle = abs_j <= ROW_W'(r_sat);
    // (|j|-1)^2 = |j|^2 - (2|j| - 1); row zero uses r^2 for both edges
    odd_d  = (abs_j == '0) ? '0 : ({abs_j[RADIUS_W-1:0], 1'b0} - ODD_W'(1));
  end

  assign push_o     = s2_valid_q && !full_i;
  assign s2_free    = !s2_valid_q || !full_i;
  assign s1_go      = !s1_valid_q || s2_free;
  assign in_ready_o = s1_go;

  assign n2        = s2_rr_q - s2_aa_q;
  assign job_o.row = s2_row_q;
  assign job_o.t   = s2_t_q;
  assign job_o.n2  = n2;
  assign job_o.n1  = n2 + SQ_W'(s2_odd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid_q <= in_valid_i && in_circle;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s1_row_q <= row_offset_i;
      s1_aj_q  <= abs_j[RADIUS_W-1:0];
      s1_r_q   <= r_sat;
      s1_t_q   <= t_sat;
      s1_odd_q <= odd_d;
    end
    if (s2_free) begin
      s2_row_q <= s1_row_q;
      s2_t_q   <= s1_t_q;
      s2_odd_q <= s1_odd_q;
      s2_rr_q  <= SQ_W'(s1_r_q) * SQ_W'(s1_r_q);
      s2_aa_q  <= SQ_W'(s1_aj_q) * SQ_W'(s1_aj_q);
    end
  end

  // A row blocked by a full queue must hold its radicands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && full_i |=> s2_valid_q && $stable(s2_rr_q) && $stable(s2_aa_q))
    else $error("front: stalled row lost or changed");

endmodule

// ===== rtl/cosg_queue.sv =====
// Short first-word-fall-through queue between the front and back ends.
module cosg_queue #(
  parameter int DEPTH = cosg_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cosg_pkg::cosg_job_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output cosg_pkg::cosg_job_t data_o,
  output logic                empty_o
);
  import cosg_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cosg_job_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q;
  logic [AW-1:0]   rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue: pop while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue: push while full");

endmodule

// ===== rtl/cosg_root.sv =====
// Pipelined integer square root with round-half-up, two result bits per stage.
module cosg_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [cosg_pkg::SQ_W-1:0]     n_i,
  input  cosg_pkg::cosg_tag_t           tag_i,
  output logic                          valid_o,
  output logic [cosg_pkg::RT_W-1:0]     x_o,
  output cosg_pkg::cosg_tag_t           tag_o
);
  import cosg_pkg::*;

  root_st_t        init;
  root_st_t        st_nxt [N_STAGES];
  root_st_t        st_q   [N_STAGES];
  cosg_tag_t       tag_q  [N_STAGES];
  logic [N_STAGES-1:0] vld_q;
  root_st_t        last;
  logic [RT_W-1:0] rounded;

  logic            rd_valid_q;
  logic [RT_W-1:0] rd_x_q;
  cosg_tag_t       rd_tag_q;

  assign init.rest = n_i;
  assign init.rem  = '0;
  assign init.root = '0;

  for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_nxt[k] = root_stage(init);
    end else begin : g_next
      assign st_nxt[k] = root_stage(st_q[k-1]);
    end
  end

  // Remainder n - s^2 exceeds s exactly when sqrt(n) >= s + 1/2.
  assign last    = st_q[N_STAGES-1];
  assign rounded = last.root + RT_W'(last.rem > REM_W'(last.root));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q      <= {vld_q[N_STAGES-2:0], valid_i};
      rd_valid_q <= vld_q[N_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N_STAGES; k++) begin
        st_q[k] <= st_nxt[k];
      end
      tag_q[0] <= tag_i;
      for (int k = 1; k < N_STAGES; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      rd_x_q   <= rounded;
      rd_tag_q <= tag_q[N_STAGES-1];
    end
  end

  assign valid_o = rd_valid_q;
  assign x_o     = rd_x_q;
  assign tag_o   = rd_tag_q;

endmodule

// ===== rtl/cosg_back.sv =====
// Back end: issues two roots per row, pairs the edges and emits both spans.
module cosg_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  cosg_pkg::cosg_job_t                job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cosg_pkg::ROW_W-1:0]  span_row_o,
  output logic signed [cosg_pkg::COL_W-1:0]  x_from_o,
  output logic signed [cosg_pkg::COL_W-1:0]  x_to_o,
  output logic                               is_left_o,
  output logic                               last_o
);
  import cosg_pkg::*;

  logic            phase_q;
  logic            en;
  logic            out_free;
  logic            load;
  logic            rd_valid;
  logic [RT_W-1:0] rd_x;
  cosg_tag_t       rd_tag;
  cosg_tag_t       issue_tag;
  logic [SQ_W-1:0] issue_n;
  logic [RT_W-1:0] p_hold_q;

  logic [COL_W-1:0] p_ext;
  logic [COL_W-1:0] q_ext;
  logic [COL_W-1:0] t_ext;

  logic                    out_valid_q;
  logic                    out_left_q;
  logic signed [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0]        rf_q;
  logic [COL_W-1:0]        rt_q;
  logic [COL_W-1:0]        lf_q;
  logic [COL_W-1:0]        lt_q;

  // Outer edge first, inner edge second, then pop the row.
  assign issue_n          = phase_q ? job_i.n2 : job_i.n1;
  assign issue_tag.row    = job_i.row;
  assign issue_tag.t      = job_i.t;
  assign issue_tag.second = phase_q;

  assign out_free = !out_valid_q || (out_left_q && out_ready_i);
  assign en       = !rd_valid || !rd_tag.second || out_free;
  assign load     = rd_valid && rd_tag.second && out_free;
  assign pop_o    = en && !empty_i && phase_q;

  cosg_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (!empty_i),
    .n_i     (issue_n),
    .tag_i   (issue_tag),
    .valid_o (rd_valid),
    .x_o     (rd_x),
    .tag_o   (rd_tag)
  );

  assign p_ext = COL_W'(p_hold_q);
  assign q_ext = COL_W'(rd_x);
  assign t_ext = COL_W'(rd_tag.t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_left_q  <= 1'b0;
    end else begin
      if (en && !empty_i) begin
        phase_q <= !phase_q;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        out_left_q  <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        if (!out_left_q) begin
          out_left_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b0;
          out_left_q  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && rd_valid && !rd_tag.second) begin
      p_hold_q <= rd_x;
    end
    if (load) begin
      out_row_q <= rd_tag.row;
      rf_q      <= q_ext;
      rt_q      <= p_ext + t_ext - COL_W'(1);
      lf_q      <= COL_W'(0) - p_ext;
      lt_q      <= t_ext - COL_W'(1) - q_ext;
    end
  end

  assign out_valid_o = out_valid_q;
  assign span_row_o  = out_row_q;
  assign x_from_o    = $signed(out_left_q ? lf_q : rf_q);
  assign x_to_o      = $signed(out_left_q ? lt_q : rt_q);
  assign is_left_o   = out_left_q;
  assign last_o      = out_left_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_left_q |-> out_valid_q)
    else $error("back: left span flagged with no span held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_left_q && out_ready_i |=> out_valid_q && out_left_q)
    else $error("back: right span not followed by left span");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid && rd_tag.second && !out_free |=> rd_valid && $stable(rd_x))
    else $error("back: inner edge lost while output busy");

endmodule
